FILE: design/aip_pkg.sv
// Package for the ASCII integer parser: payload types and character constants.
package aip_pkg;

    // ASCII codes that the parser looks at
    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_UP_A  = 8'd65;
    localparam logic [7:0] CHAR_UP_F  = 8'd70;
    localparam logic [7:0] CHAR_LO_A  = 8'd97;
    localparam logic [7:0] CHAR_LO_F  = 8'd102;
    localparam logic [7:0] CHAR_LO_X  = 8'd120;

    // Letter digits keep their low nibble offset by nine from their value
    localparam logic [3:0] LETTER_OFFSET = 4'd9;

    // Character position saturates at two
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LATER  = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               parse_error;
    } result_item_t;

endpackage

FILE: design/ascii_integer_parser.sv
// ASCII integer parser: streams characters in and gives one signed value per string.
//
// Usage
//   Characters arrive one per transfer on the char channel (char_valid,
//   char_stall, char_item). The item marked last_char closes the string's
//   buffer and causes exactly one transfer on the result channel
//   (result_valid, result_stall, result_item) carrying the value and an
//   error flag. The string itself ends at the first NUL; later characters
//   only wait for the last_char mark. force_hex must be written by the user
//   through write_enable and write_data only while the block is idle (not enforced).
// Dataflow
//   A character is taken into an input register, processed in the next
//   cycle against the string state and, if it is the last, lands in the
//   result register, which drives result_valid. One character is
//   accepted every cycle unless the input stage stalls; the shift-add
//   update of the decimal and hexadecimal accumulators is combinational.
// Reset and back-pressure
//   rst_n clears the string state, force_hex and both valid flags.
//   While a result waits under result_stall, characters that carry no
//   last_char mark still flow; the input stage only stalls when it holds
//   a closing character and the result register is occupied and stalled.
module ascii_integer_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  write_enable,
    input  logic                  write_data,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  aip_pkg::char_item_t   char_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output aip_pkg::result_item_t result_item
);

    // Configuration
    logic force_hex_reg;

    // Input stage
    logic                s1_valid_reg, s1_valid_next;
    aip_pkg::char_item_t s1_item_reg;

    // String state
    logic [1:0]  pos_reg, pos_next;
    logic        ended_reg, ended_next;
    logic        minus_reg, minus_next;
    logic        zero_reg, zero_next;
    logic        prefix_reg, prefix_next;
    logic [31:0] dec_reg, dec_next;
    logic [31:0] neg_reg, neg_next;
    logic        dec_bad_reg, dec_bad_next;
    logic [31:0] hex_reg, hex_next;
    logic        hex_bad_reg, hex_bad_next;

    // Result stage
    logic                  out_valid_reg, out_valid_next;
    aip_pkg::result_item_t out_item_reg, out_item_next;

    logic       advance;
    logic       accept;
    logic [7:0] c;
    logic       take;
    logic       is_dec, is_lower, is_upper, is_x;
    logic [3:0] nibble;
    logic       hex_mode;
    logic       err;

    assign c = s1_item_reg.char_code;

    // The input stage moves on unless it closes a string and the result
    // register cannot be freed in this cycle.
    assign advance    = s1_valid_reg &&
                        (!s1_item_reg.last_char || !out_valid_reg || !result_stall);
    assign char_stall = s1_valid_reg && !advance;
    assign accept     = char_valid && !char_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_hex_reg <= 1'b0;
        end
        else if (write_enable)
        begin
            force_hex_reg <= write_data;
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= char_item;
        end
    end

    // Character classes
    always_comb
    begin
        is_dec   = c inside {[aip_pkg::CHAR_ZERO : aip_pkg::CHAR_NINE]};
        is_lower = c inside {[aip_pkg::CHAR_LO_A : aip_pkg::CHAR_LO_F]};
        is_upper = c inside {[aip_pkg::CHAR_UP_A : aip_pkg::CHAR_UP_F]};
        is_x     = (c == aip_pkg::CHAR_LO_X);
        nibble   = is_dec ? c[3:0] : c[3:0] + aip_pkg::LETTER_OFFSET;
    end

    assign take = !ended_reg && (c != aip_pkg::CHAR_NUL);

    // String state update for the character in the input stage. Both
    // the decimal value and its negation are kept, so that a leading
    // minus costs no extra adder on the closing character.
    always_comb
    begin
        pos_next     = pos_reg;
        ended_next   = ended_reg;
        minus_next   = minus_reg;
        zero_next    = zero_reg;
        prefix_next  = prefix_reg;
        dec_next     = dec_reg;
        neg_next     = neg_reg;
        dec_bad_next = dec_bad_reg;
        hex_next     = hex_reg;
        hex_bad_next = hex_bad_reg;

        if (!ended_reg && (c == aip_pkg::CHAR_NUL))
        begin
            ended_next = 1'b1;
        end

        if (take)
        begin
            if ((pos_reg == aip_pkg::POS_FIRST) && (c == aip_pkg::CHAR_ZERO))
            begin
                zero_next = 1'b1;
            end
            if ((pos_reg == aip_pkg::POS_SECOND) && is_x && zero_reg)
            begin
                prefix_next = 1'b1;
            end

            if ((pos_reg == aip_pkg::POS_FIRST) && (c == aip_pkg::CHAR_MINUS))
            begin
                minus_next = 1'b1;
            end
            else if (is_dec)
            begin
                dec_next = (dec_reg << 3) + (dec_reg << 1) + {28'd0, c[3:0]};
                neg_next = (neg_reg << 3) + (neg_reg << 1) - {28'd0, c[3:0]};
            end
            else
            begin
                dec_bad_next = 1'b1;
            end

            // The rightmost lowercase x restarts the hexadecimal reading
            if (is_x)
            begin
                hex_next     = '0;
                hex_bad_next = 1'b0;
            end
            else if (is_dec || is_lower || is_upper)
            begin
                hex_next = {hex_reg[27:0], nibble};
            end
            else
            begin
                hex_bad_next = 1'b1;
            end

            if (pos_reg != aip_pkg::POS_LATER)
            begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    // Result of the string, taken from the state after this character
    always_comb
    begin
        hex_mode = force_hex_reg || prefix_next;
        err      = (hex_mode ? hex_bad_next : dec_bad_next) ||
                   (pos_next == aip_pkg::POS_FIRST);
        if (err)
        begin
            out_item_next.value = '0;
        end
        else if (hex_mode)
        begin
            out_item_next.value = hex_next;
        end
        else
        begin
            out_item_next.value = minus_next ? neg_next : dec_next;
        end
        out_item_next.parse_error = err;
    end

    // String state: updated on every character that leaves the input
    // stage, and cleared once the closing character has been turned into
    // a result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= aip_pkg::POS_FIRST;
            ended_reg   <= 1'b0;
            minus_reg   <= 1'b0;
            zero_reg    <= 1'b0;
            prefix_reg  <= 1'b0;
            dec_reg     <= '0;
            neg_reg     <= '0;
            dec_bad_reg <= 1'b0;
            hex_reg     <= '0;
            hex_bad_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (s1_item_reg.last_char)
            begin
                pos_reg     <= aip_pkg::POS_FIRST;
                ended_reg   <= 1'b0;
                minus_reg   <= 1'b0;
                zero_reg    <= 1'b0;
                prefix_reg  <= 1'b0;
                dec_reg     <= '0;
                neg_reg     <= '0;
                dec_bad_reg <= 1'b0;
                hex_reg     <= '0;
                hex_bad_reg <= 1'b0;
            end
            else
            begin
                pos_reg     <= pos_next;
                ended_reg   <= ended_next;
                minus_reg   <= minus_next;
                zero_reg    <= zero_next;
                prefix_reg  <= prefix_next;
                dec_reg     <= dec_next;
                neg_reg     <= neg_next;
                dec_bad_reg <= dec_bad_next;
                hex_reg     <= hex_next;
                hex_bad_reg <= hex_bad_next;
            end
        end
    end

    // Result register: loaded by a closing character, emptied by a transfer
    always_comb
    begin
        if (advance && s1_item_reg.last_char)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_item_reg.last_char)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule

FILE: design/aip_checker.sv
// Port-level checker for the ASCII integer parser, bound to the top level.
module aip_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  char_valid,
    input logic                  char_stall,
    input logic                  result_valid,
    input logic                  result_stall,
    input aip_pkg::result_item_t result_item
);

    // A waiting result stays put until it is transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
        else $error("result changed or dropped while stalled");

    // An error result always carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.parse_error |-> result_item.value == 32'sd0)
        else $error("error result with non-zero value");

    // Characters are only held back by a blocked result.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> result_valid && result_stall)
        else $error("character stalled without a blocked result");

    // A result cannot appear without an earlier character transfer or a stalled character.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(char_valid && !char_stall, 2) || $past(char_stall))
        else $error("result appeared without a closing character");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);
